/* sv/dcs_pkg.sv */
// Shared constants, types and status codes of the discrete CDF sampler.
`default_nettype none
package dcs_pkg;

	localparam int MAX_WEIGHTS = 256;
	localparam int WEIGHT_W    = 18;
	localparam int U_W         = 32;
	localparam int IDX_W       = $clog2(MAX_WEIGHTS);
	localparam int CNT_W       = IDX_W + 1;
	localparam int SUM_W       = WEIGHT_W + IDX_W;
	localparam int THR_W       = SUM_W + 1;
	localparam int PROD_W      = U_W + SUM_W;
	localparam int ST_W        = 3;
	localparam int OUT_IDX_W   = 8;
	localparam int OUT_SIZE_W  = 9;

	localparam logic [SUM_W-1:0] ONE_FIXED = SUM_W'(65536);

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_NEG      = 3'd1;
	localparam logic [ST_W-1:0] ST_NONPOS   = 3'd2;
	localparam logic [ST_W-1:0] ST_OVER_ONE = 3'd3;
	localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd4;
	localparam logic [ST_W-1:0] ST_MISS     = 3'd5;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DRAW = 1'b1;

	// Search token passed from cell to cell during a draw.
	typedef struct packed {
		logic             valid;
		logic             found;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] pos;
	} tok_t;

	// Load broadcast to every cell.
	typedef struct packed {
		logic             en;
		logic             start;
		logic [SUM_W-1:0] data;
	} ld_t;

endpackage
`default_nettype wire

/* sv/dcs_stream_if.sv */
// Valid/ready stream interfaces for the request and result channels.
`default_nettype none
interface dcs_req_if;
	logic                           valid;
	logic                           ready;
	logic                           cmd;
	logic signed [dcs_pkg::WEIGHT_W-1:0] weight;
	logic                           last_weight;
	logic [dcs_pkg::U_W-1:0]        uniform_draw;
	modport source (output valid, cmd, weight, last_weight, uniform_draw, input ready);
	modport sink (input valid, cmd, weight, last_weight, uniform_draw, output ready);
endinterface

interface dcs_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [dcs_pkg::OUT_IDX_W-1:0]    drawn_index;
	logic [dcs_pkg::ST_W-1:0]         status;
	logic [dcs_pkg::OUT_SIZE_W-1:0]   table_size;
	modport source (output valid, drawn_index, status, table_size, input ready);
	modport sink (input valid, drawn_index, status, table_size, output ready);
endinterface
`default_nettype wire

/* sv/dcs_cell.sv */
// One cell of the table: holds one cumulative sum and tests the passing search token.
`default_nettype none
module dcs_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dcs_pkg::ld_t                ld,
	input  logic                        head,
	input  logic                        sel_in,
	output logic                        sel_out,
	input  logic [dcs_pkg::THR_W-1:0]   thr,
	input  dcs_pkg::tok_t               tok_in,
	output dcs_pkg::tok_t               tok_out
);
	import dcs_pkg::*;

	logic             ptr_q;
	logic             loaded_q;
	logic [SUM_W-1:0] cum_q;
	tok_t             tok_q;
	logic             sel;
	logic             hit;

	// The write pointer is one-hot along the row; a new table restarts it at the head.
	assign sel     = ld.en & (ld.start ? head : ptr_q);
	assign sel_out = sel;
	assign hit     = loaded_q && (cum_q != '0) && ({1'b0, cum_q} >= thr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= 1'b0;
			loaded_q <= 1'b0;
		end else if (ld.en) begin
			ptr_q    <= sel_in;
			loaded_q <= ld.start ? sel : (loaded_q | sel);
		end
	end

	always_ff @(posedge clk) begin
		if (sel) begin
			cum_q <= ld.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_in.valid;
			tok_q.found <= tok_in.found | hit;
			tok_q.idx   <= tok_in.found ? tok_in.idx : tok_in.pos;
			tok_q.pos   <= tok_in.pos + IDX_W'(1);
		end
	end

	assign tok_out = tok_q;

endmodule
`default_nettype wire

/* sv/discrete_cdf_sampler_core.sv */
// Top level of the discrete CDF sampler: load/draw control and the row of table cells.
// Loads can be accepted back to back while the result register is free; the closing load
// returns its status in the cycle after the transaction. A draw with a valid table runs
// S_MUL (u times the table total, or times one without normalization), S_THR (the
// threshold) and S_LAUNCH; the search token then walks the row and picks up the first
// entry whose cumulative sum reaches the threshold. A draw without a valid table answers
// in the cycle after it is accepted. Items are processed one at a time; the result
// register lets the next item be accepted in the cycle the previous result is taken. The
// cumulative table needs no clearing after reset; the normalize_mode register resets to 1.
`default_nettype none
module discrete_cdf_sampler_core (
	input  logic       clk,
	input  logic       arst_n,
	dcs_req_if.sink    req,
	dcs_rsp_if.source  rsp,
	input  logic       cfg_we,
	input  logic       cfg_wdata
);
	import dcs_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_MUL    = 3'd1;
	localparam logic [2:0] S_THR    = 3'd2;
	localparam logic [2:0] S_LAUNCH = 3'd3;
	localparam logic [2:0] S_RUN    = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0]        state_q;
	logic              norm_q;
	logic              mode_q;
	logic              loading_q;
	logic              valid_q;
	logic [CNT_W-1:0]  cnt_q;
	logic signed [SUM_W-1:0] total_q;
	logic [SUM_W-1:0]  pos_sum_q;
	logic [ST_W-1:0]   err_q;
	logic [U_W-1:0]    u_q;
	logic [PROD_W-1:0] prod_s1;
	logic [THR_W-1:0]  thr_q;
	logic [IDX_W-1:0]  res_idx_q;
	logic [ST_W-1:0]   res_st_q;

	logic                   out_v_q;
	logic [OUT_IDX_W-1:0]   out_idx_q;
	logic [ST_W-1:0]        out_st_q;
	logic [OUT_SIZE_W-1:0]  out_sz_q;

	logic              out_free;
	logic              acc;
	logic              acc_load;
	logic              acc_draw;
	logic              start;
	logic [CNT_W-1:0]  base_cnt;
	logic signed [SUM_W-1:0] base_tot;
	logic [SUM_W-1:0]  base_pos;
	logic [ST_W-1:0]   base_err;
	logic              ovf;
	logic [CNT_W-1:0]  new_cnt;
	logic signed [SUM_W-1:0] new_tot;
	logic [SUM_W-1:0]  new_pos;
	logic [ST_W-1:0]   new_err;
	logic [ST_W-1:0]   close_st;
	logic signed [SUM_W-1:0] w_ext;
	logic [SUM_W-1:0]  w_pos;
	logic [SUM_W-1:0]  draw_total;

	ld_t               ld;
	tok_t              tok [0:MAX_WEIGHTS];
	logic              sel [0:MAX_WEIGHTS];

	assign out_free = !out_v_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign acc      = req.valid && req.ready;
	assign acc_load = acc && (req.cmd == CMD_LOAD);
	assign acc_draw = acc && (req.cmd == CMD_DRAW);

	assign w_ext = SUM_W'(req.weight);
	assign w_pos = req.weight[WEIGHT_W-1] ? '0 : SUM_W'(unsigned'(req.weight));

	// The first load after a closed table starts a fresh one.
	assign start    = !loading_q;
	assign base_cnt = start ? '0 : cnt_q;
	assign base_tot = start ? '0 : total_q;
	assign base_pos = start ? '0 : pos_sum_q;
	assign base_err = start ? ST_OK : err_q;
	assign ovf      = base_cnt >= CNT_W'(MAX_WEIGHTS);
	assign new_cnt  = ovf ? base_cnt : base_cnt + CNT_W'(1);
	assign new_tot  = ovf ? base_tot : base_tot + w_ext;
	assign new_pos  = ovf ? base_pos : base_pos + w_pos;

	always_comb begin
		new_err = base_err;
		if (ovf) begin
			new_err = ST_OVERFLOW;
		end else if (req.weight[WEIGHT_W-1] && base_err == ST_OK) begin
			new_err = ST_NEG;
		end
	end

	always_comb begin
		close_st = ST_OK;
		if (new_err == ST_OVERFLOW) begin
			close_st = ST_OVERFLOW;
		end else if (norm_q && new_tot <= 0) begin
			close_st = ST_NONPOS;
		end else if (new_err == ST_NEG) begin
			close_st = ST_NEG;
		end else if (!norm_q && new_cnt != '0 && new_pos > ONE_FIXED) begin
			close_st = ST_OVER_ONE;
		end
	end

	assign draw_total = mode_q ? unsigned'(total_q) : ONE_FIXED;

	assign ld.en    = acc_load;
	assign ld.start = start;
	assign ld.data  = new_pos;

	assign tok[0].valid = (state_q == S_LAUNCH);
	assign tok[0].found = 1'b0;
	assign tok[0].idx   = '0;
	assign tok[0].pos   = '0;
	assign sel[0]       = 1'b0;

	for (genvar i = 0; i < MAX_WEIGHTS; i++) begin : g_cell
		dcs_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ld      (ld),
			.head    (i == 0),
			.sel_in  (sel[i]),
			.sel_out (sel[i+1]),
			.thr     (thr_q),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_q <= 1'b1;
		end else if (cfg_we) begin
			norm_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b1;
			loading_q <= 1'b0;
			valid_q   <= 1'b0;
			cnt_q     <= '0;
			total_q   <= '0;
			pos_sum_q <= '0;
			err_q     <= ST_OK;
		end else if (acc_load) begin
			cnt_q     <= new_cnt;
			total_q   <= new_tot;
			pos_sum_q <= new_pos;
			if (req.last_weight) begin
				loading_q <= 1'b0;
				mode_q    <= norm_q;
				err_q     <= close_st;
				valid_q   <= (close_st == ST_OK);
			end else begin
				loading_q <= 1'b1;
				err_q     <= new_err;
				valid_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc_draw && valid_q && !loading_q) begin
						state_q <= S_MUL;
					end
				end
				S_MUL:    state_q <= S_THR;
				S_THR:    state_q <= S_LAUNCH;
				S_LAUNCH: state_q <= S_RUN;
				S_RUN: begin
					if (tok[MAX_WEIGHTS].valid) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// C * 2^32 >= u * T is the same as C >= ceil(u * T / 2^32).
	always_ff @(posedge clk) begin
		if (acc_draw) begin
			u_q <= req.uniform_draw;
		end
		if (state_q == S_MUL) begin
			prod_s1 <= u_q * draw_total;
		end
		if (state_q == S_THR) begin
			thr_q <= THR_W'(prod_s1[PROD_W-1:U_W]) + THR_W'(prod_s1[U_W-1:0] != '0);
		end
		if (state_q == S_RUN && tok[MAX_WEIGHTS].valid) begin
			res_idx_q <= tok[MAX_WEIGHTS].found ? tok[MAX_WEIGHTS].idx : '0;
			res_st_q  <= tok[MAX_WEIGHTS].found ? ST_OK : ST_MISS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if ((acc_load && req.last_weight) || (acc_draw && !(valid_q && !loading_q))
				|| (state_q == S_DONE && out_free)) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_load && req.last_weight) begin
			out_idx_q <= '0;
			out_st_q  <= close_st;
			out_sz_q  <= OUT_SIZE_W'(new_cnt);
		end else if (acc_draw && !(valid_q && !loading_q)) begin
			out_idx_q <= '0;
			out_st_q  <= ST_MISS;
			out_sz_q  <= OUT_SIZE_W'(cnt_q);
		end else if (state_q == S_DONE && out_free) begin
			out_idx_q <= OUT_IDX_W'(res_idx_q);
			out_st_q  <= res_st_q;
			out_sz_q  <= OUT_SIZE_W'(cnt_q);
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.drawn_index  = out_idx_q;
	assign rsp.status       = out_st_q;
	assign rsp.table_size   = out_sz_q;

endmodule
`default_nettype wire

/* sv/dcs_checker.sv */
// Port-level checks of the sampler results, bound to the top level.
`default_nettype none
module dcs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] drawn_index,
	input logic [2:0] status,
	input logic [8:0] table_size
);
	import dcs_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(drawn_index)
		&& $stable(table_size))
		else $error("result changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status <= ST_MISS)
		else $error("undefined status code");

	a_fail_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> drawn_index == '0)
		else $error("failed transaction carries a nonzero index");

	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> table_size <= 9'(MAX_WEIGHTS))
		else $error("table size beyond capacity");

	a_index_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_OK && drawn_index != '0 |-> 9'(drawn_index) < table_size)
		else $error("drawn index outside the loaded table");

endmodule

bind discrete_cdf_sampler_core dcs_checker u_dcs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.drawn_index  (rsp.drawn_index),
	.status       (rsp.status),
	.table_size   (rsp.table_size)
);
`default_nettype wire
